>>> src/bbe_pkg.sv
// bbe_pkg: shared types and constants for the bernstein basis evaluator
// holds pipeline control structs, span-select codes and register map
// no dependencies
package bbe_pkg;

	// how t is formed from the span test
	typedef enum logic [1:0] {
		TSEL_ZERO,
		TSEL_ONE,
		TSEL_DIV
	} tsel_t;

	// control that travels with an item through the divider
	typedef struct packed {
		logic  valid;
		logic  flag;
		tsel_t sel;
	} div_ctl_t;

	// control that travels with an item through the recurrence
	typedef struct packed {
		logic valid;
		logic flag;
	} rec_ctl_t;

	// configuration port
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_ORDER     = 2'd0;
	localparam logic [1:0] REG_KNOT_LOW  = 2'd1;
	localparam logic [1:0] REG_KNOT_HIGH = 2'd2;

	// field widths
	localparam int ORDER_W = 4;
	localparam int X_W     = 32;
	localparam int IDX_W   = 3;
	localparam int VAL_W   = 17;

	// register reset values
	localparam logic [ORDER_W-1:0] ORDER_RST     = 4'd4;
	localparam logic [X_W-1:0]     KNOT_LOW_RST  = 32'd0;
	localparam logic [X_W-1:0]     KNOT_HIGH_RST = 32'd65536;

endpackage

>>> src/bernstein_basis_evaluator.sv
// bernstein_basis_evaluator: stages from an accepted param_x beat to its first result beat:
// span subtract, span test, one divider stage per quotient bit, t/u stage, one stage per
// recurrence row, output register. A new param_x may enter every cycle unless a finished item
// stalls the pipeline; the single result channel emits one beat per cycle while out_ready is
// high, n beats per item, n = effective order (1..MAX_ORDER).
// reset (arst_n, asynchronous): pipeline emptied, order = 4, knot_low = 0, knot_high = 1.0.
module bernstein_basis_evaluator #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           param_x,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   basis_index,
	output logic [16:0]                  basis_value,
	output logic                         out_of_span,
	output logic                         last,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbe_pkg::CFG_AW-1:0]   paddr,
	input  logic [bbe_pkg::CFG_DW-1:0]   pwdata,
	output logic [bbe_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready
);
	import bbe_pkg::*;

	localparam int VW = FRAC_BITS + 1;
	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [ORDER_W-1:0] order_q;
	logic [X_W-1:0]     knot_low_q;
	logic [X_W-1:0]     knot_high_q;

	logic               en;
	logic [4:0]         ord5;
	logic [4:0]         n_sat;
	logic [CW-1:0]      n_eff;
	logic [CW-1:0]      n_m1;

	logic               valid_s1;
	logic signed [32:0] diff_s1;
	logic signed [32:0] span_s1;

	div_ctl_t           ctl_nxt;
	div_ctl_t           ctl_s2;
	logic [31:0]        rem_s2;
	logic [31:0]        den_s2;

	div_ctl_t             div_out_ctl;
	logic [FRAC_BITS-1:0] div_quo;

	rec_ctl_t           rctl_s3;
	logic [VW-1:0]      t_nxt;
	logic [VW-1:0]      t_s3;
	logic [VW-1:0]      u_s3;

	rec_ctl_t                     rec_out_ctl;
	logic [MAX_ORDER-1:0][VW-1:0] rec_b;

	logic                         ser_valid_q;
	logic [IW-1:0]                idx_q;
	logic [MAX_ORDER-1:0][VW-1:0] hold_b_q;
	logic                         hold_flag_q;
	logic                         last_beat;
	logic                         ser_take;
	logic [IW+IDX_W-1:0]          idx_ext;
	logic [VW+VAL_W-1:0]          val_ext;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= ORDER_RST;
			knot_low_q  <= KNOT_LOW_RST;
			knot_high_q <= KNOT_HIGH_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ORDER:     order_q     <= pwdata[ORDER_W-1:0];
				REG_KNOT_LOW:  knot_low_q  <= pwdata[X_W-1:0];
				REG_KNOT_HIGH: knot_high_q <= pwdata[X_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		case (paddr[3:2])
			REG_ORDER:     prdata = {{(CFG_DW-ORDER_W){1'b0}}, order_q};
			REG_KNOT_LOW:  prdata = knot_low_q;
			REG_KNOT_HIGH: prdata = knot_high_q;
			default:       prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// effective order, clamped to 1..MAX_ORDER
	assign ord5  = {1'b0, order_q};
	assign n_sat = (ord5 == 5'd0) ? 5'd1 :
		(ord5 > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : ord5;
	assign n_eff = CW'(n_sat);
	assign n_m1  = n_eff - 1'b1;

	// stage 1: distances from the left knot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= {param_x[31], param_x} - {knot_low_q[31], knot_low_q};
			span_s1 <= {knot_high_q[31], knot_high_q} - {knot_low_q[31], knot_low_q};
		end
	end

	// stage 2: span test, saturation and divider operands
	always_comb begin
		ctl_nxt.valid = valid_s1;
		ctl_nxt.flag  = 1'b0;
		ctl_nxt.sel   = TSEL_DIV;
		if (span_s1[32] || span_s1 == '0) begin
			ctl_nxt.sel  = TSEL_ZERO;
			ctl_nxt.flag = 1'b1;
		end else if (diff_s1[32]) begin
			ctl_nxt.sel  = TSEL_ZERO;
			ctl_nxt.flag = 1'b1;
		end else if (diff_s1 >= span_s1) begin
			ctl_nxt.sel  = TSEL_ONE;
			ctl_nxt.flag = diff_s1 > span_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= diff_s1[31:0];
			den_s2 <= span_s1[31:0];
		end
	end

	// t = diff * 1.0 / span
	bbe_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (ctl_s2),
		.in_rem  (rem_s2),
		.in_den  (den_s2),
		.out_ctl (div_out_ctl),
		.out_quo (div_quo)
	);

	// stage 3: pick t, form u = 1.0 - t
	always_comb begin
		case (div_out_ctl.sel)
			TSEL_ZERO: t_nxt = '0;
			TSEL_ONE:  t_nxt = ONE;
			TSEL_DIV:  t_nxt = {1'b0, div_quo};
			default:   t_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctl_s3 <= '0;
		end else if (en) begin
			rctl_s3.valid <= div_out_ctl.valid;
			rctl_s3.flag  <= div_out_ctl.flag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t_nxt;
			u_s3 <= ONE - t_nxt;
		end
	end

	// recurrence rows
	bbe_rec #(
		.MAX_ORDER(MAX_ORDER),
		.FRAC_BITS(FRAC_BITS)
	) u_rec (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.n_eff   (n_eff),
		.in_ctl  (rctl_s3),
		.t_in    (t_s3),
		.u_in    (u_s3),
		.out_ctl (rec_out_ctl),
		.out_b   (rec_b)
	);

	// pipeline advances unless a finished item waits on a busy output register
	assign last_beat = CW'(idx_q) == n_m1;
	assign ser_take  = !ser_valid_q || (out_ready && last_beat);
	assign en        = !rec_out_ctl.valid || ser_take;
	assign in_ready  = en;

	// output register: one beat per basis value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (ser_take) begin
			ser_valid_q <= rec_out_ctl.valid;
			idx_q       <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take) begin
			hold_b_q    <= rec_b;
			hold_flag_q <= rec_out_ctl.flag;
		end
	end

	// result beat fields
	assign idx_ext     = {{IDX_W{1'b0}}, idx_q};
	assign val_ext     = {{VAL_W{1'b0}}, hold_b_q[idx_q]};
	assign out_valid   = ser_valid_q;
	assign basis_index = idx_ext[IDX_W-1:0];
	assign basis_value = val_ext[VAL_W-1:0];
	assign out_of_span = hold_flag_q;
	assign last        = last_beat;

endmodule

>>> src/bbe_div.sv
// bbe_div: pipelined restoring divider, one quotient bit per stage
// produces floor(rem * 2^FRAC_BITS / den) for rem < den
// depends on bbe_pkg
module bbe_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  bbe_pkg::div_ctl_t      in_ctl,
	input  logic [31:0]            in_rem,
	input  logic [31:0]            in_den,
	output bbe_pkg::div_ctl_t      out_ctl,
	output logic [FRAC_BITS-1:0]   out_quo
);
	import bbe_pkg::*;

	// stage inputs, row 0 is the module input
	div_ctl_t             row_ctl [FRAC_BITS+1];
	logic [31:0]          row_rem [FRAC_BITS+1];
	logic [31:0]          row_den [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] row_quo [FRAC_BITS+1];

	assign row_ctl[0] = in_ctl;
	assign row_rem[0] = in_rem;
	assign row_den[0] = in_den;
	assign row_quo[0] = '0;

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
		div_ctl_t             ctl_s;
		logic [31:0]          rem_s;
		logic [31:0]          den_s;
		logic [FRAC_BITS-1:0] quo_s;
		logic [32:0]          r2;
		logic [32:0]          r2_sub;
		logic                 ge;

		// shift remainder, trial subtract
		assign r2     = {row_rem[k], 1'b0};
		assign r2_sub = r2 - {1'b0, row_den[k]};
		assign ge     = r2 >= {1'b0, row_den[k]};

		// valid bit and control
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else if (en) begin
				ctl_s <= row_ctl[k];
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= ge ? r2_sub[31:0] : r2[31:0];
				den_s <= row_den[k];
				quo_s <= {row_quo[k][FRAC_BITS-2:0], ge};
			end
		end

		assign row_ctl[k+1] = ctl_s;
		assign row_rem[k+1] = rem_s;
		assign row_den[k+1] = den_s;
		assign row_quo[k+1] = quo_s;
	end

	assign out_ctl = row_ctl[FRAC_BITS];
	assign out_quo = row_quo[FRAC_BITS];

endmodule

>>> src/bbe_rec.sv
// bbe_rec: triangular bernstein recurrence, one row per pipeline stage
// row j is applied only while j+1 is below the effective order
// depends on bbe_pkg
module bbe_rec #(
	parameter int MAX_ORDER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic [$clog2(MAX_ORDER+1)-1:0]        n_eff,
	input  bbe_pkg::rec_ctl_t                     in_ctl,
	input  logic [FRAC_BITS:0]                    t_in,
	input  logic [FRAC_BITS:0]                    u_in,
	output bbe_pkg::rec_ctl_t                     out_ctl,
	output logic [MAX_ORDER-1:0][FRAC_BITS:0]     out_b
);
	import bbe_pkg::*;

	localparam int VW = FRAC_BITS + 1;
	localparam int PW = 2 * VW;
	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam logic [VW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	// stage inputs, row 0 is the module input
	rec_ctl_t                     row_ctl [MAX_ORDER];
	logic [VW-1:0]                row_t   [MAX_ORDER];
	logic [VW-1:0]                row_u   [MAX_ORDER];
	logic [MAX_ORDER-1:0][VW-1:0] row_b   [MAX_ORDER];
	logic [MAX_ORDER-1:0][VW-1:0] b_init;

	// start row: b[0] = 1.0
	always_comb begin
		b_init    = '0;
		b_init[0] = ONE;
	end

	assign row_ctl[0] = in_ctl;
	assign row_t[0]   = t_in;
	assign row_u[0]   = u_in;
	assign row_b[0]   = b_init;

	for (genvar k = 0; k < MAX_ORDER - 1; k++) begin : g_row
		rec_ctl_t                     ctl_s;
		logic [VW-1:0]                t_s;
		logic [VW-1:0]                u_s;
		logic [MAX_ORDER-1:0][VW-1:0] b_s;
		logic [MAX_ORDER-1:0][VW-1:0] b_nxt;
		logic                         active;

		assign active = CW'(k + 1) < n_eff;

		for (genvar i = 0; i < MAX_ORDER; i++) begin : g_lane
			if (i > k + 1) begin : g_idle
				assign b_nxt[i] = row_b[k][i];
			end else begin : g_work
				logic [VW-1:0] ru;
				logic [VW-1:0] rt;
				logic [VW:0]   sum;

				// u * b[i], rounded to nearest
				if (i <= k) begin : g_u
					logic [PW-1:0] pu;
					assign pu = PW'(row_u[k]) * PW'(row_b[k][i]) + HALF;
					assign ru = pu[FRAC_BITS+VW-1:FRAC_BITS];
				end else begin : g_nu
					assign ru = '0;
				end

				// t * b[i-1], rounded to nearest
				if (i > 0) begin : g_t
					logic [PW-1:0] pt;
					assign pt = PW'(row_t[k]) * PW'(row_b[k][i-1]) + HALF;
					assign rt = pt[FRAC_BITS+VW-1:FRAC_BITS];
				end else begin : g_nt
					assign rt = '0;
				end

				// sum saturated at 1.0, skipped rows pass through
				assign sum = {1'b0, ru} + {1'b0, rt};
				assign b_nxt[i] = !active ? row_b[k][i] :
					(sum > {1'b0, ONE}) ? ONE : sum[VW-1:0];
			end
		end

		// valid bit and control
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else if (en) begin
				ctl_s <= row_ctl[k];
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				t_s <= row_t[k];
				u_s <= row_u[k];
				b_s <= b_nxt;
			end
		end

		assign row_ctl[k+1] = ctl_s;
		assign row_t[k+1]   = t_s;
		assign row_u[k+1]   = u_s;
		assign row_b[k+1]   = b_s;
	end

	assign out_ctl = row_ctl[MAX_ORDER-1];
	assign out_b   = row_b[MAX_ORDER-1];

endmodule
